/* rtl/srbm_pkg.sv */
// Shared constants, codes and table port types for the segmented row block map.
// No dependencies; compile first.
package srbm_pkg;

  localparam int unsigned MAX_BLOCKS     = 16;
  localparam int unsigned LOCAL_ROW_BITS = 16;
  localparam int unsigned IDX_W          = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CNT_W          = $clog2(MAX_BLOCKS + 1);

  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_BAD   = 2'd3;

  typedef logic [LOCAL_ROW_BITS-1:0] row_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    row_t             start_row;
    row_t             end_row;
    logic [31:0]      prefix;
  } tbl_wr_t;

  typedef struct packed {
    row_t        start_row;
    row_t        end_row;
    logic [31:0] prefix;
  } tbl_rd_t;

endpackage

/* rtl/srbm_if.sv */
// Request and response channel interfaces for the segmented row block map.
// Depends on nothing; valid/ready handshake, transfer when both are high.
interface srbm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] block_start;
  logic [15:0] block_end;
  logic [31:0] row_count;
  logic [31:0] abs_row;

  modport source (output valid, req_type, block_start, block_end, row_count, abs_row,
                  input ready);
  modport sink   (input valid, req_type, block_start, block_end, row_count, abs_row,
                  output ready);
endinterface

interface srbm_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  block_index;
  logic [15:0] local_row;
  logic [31:0] rows_held;

  modport source (output valid, status, block_index, local_row, rows_held, input ready);
  modport sink   (input valid, status, block_index, local_row, rows_held, output ready);
endinterface

/* rtl/segmented_row_block_map_top.sv */
// Segmented row block map: ordered table of row blocks with prefix sums.
// Depends on srbm_pkg, srbm_if (srbm_req_if, srbm_rsp_if) and srbm_table.
//
//   channel  | dir | payload                                          | transfer
//   req_i    | in  | req_type, block_start, block_end, row_count,     | valid & ready
//            |     | abs_row                                          |
//   rsp_o    | out | status, block_index, local_row, rows_held        | valid & ready
//
// Append, rejected requests, out-of-range lookups and the unused selector go from
// idle straight to the finish state. Remove and in-range lookup walk the table in
// the scan state: the table has one read port and the sequencer walks it one entry
// per cycle.
// Reset clears the registers but not the table; entries are written before read.
// A result waits in the output register; the next request is taken while it waits,
// and its result holds in the sequencer until the output register is free.
module segmented_row_block_map_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  srbm_req_if.sink   req_i,
  srbm_rsp_if.source rsp_o
);
  import srbm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_e;

  state_e           state_q, state_d;
  logic [1:0]       op_q, op_d;
  logic [CNT_W-1:0] held_q, held_d;
  logic [31:0]      total_q, total_d;
  logic [31:0]      offset_q, offset_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] proc_q, proc_d;
  logic             rd_vld_q, rd_vld_d;
  logic [31:0]      left_q, left_d;
  logic [CNT_W-1:0] drop_q, drop_d;
  logic [31:0]      sum_q, sum_d;
  logic [31:0]      rel_q, rel_d;
  logic [IDX_W-1:0] pick_q, pick_d;
  row_t             loc_q, loc_d;
  logic [1:0]       res_stat_q, res_stat_d;
  logic             o_valid_q, o_valid_d;
  logic [1:0]       o_stat_q, o_stat_d;
  logic [3:0]       o_idx_q, o_idx_d;
  logic [15:0]      o_loc_q, o_loc_d;
  logic [31:0]      o_rows_q, o_rows_d;

  tbl_wr_t          tbl_wr;
  tbl_rd_t          tbl_rd;

  // Append operands, masked to the local row width.
  row_t             ap_s, ap_e, ap_size;
  // Remove datapath for the entry in the read register.
  row_t             rm_size, rm_new_s;
  logic [31:0]      rm_size32, rm_new_size32;
  logic             rm_drop, rm_part;
  // Lookup datapath.
  logic [31:0]      lk_rel, lk_diff;

  assign ap_s    = row_t'(req_i.block_start);
  assign ap_e    = row_t'(req_i.block_end);
  assign ap_size = ap_e - ap_s;

  assign rm_size       = tbl_rd.end_row - tbl_rd.start_row;
  assign rm_size32     = 32'(rm_size);
  assign rm_drop       = (left_q != 32'd0) && (left_q >= rm_size32);
  assign rm_part       = (left_q != 32'd0);
  assign rm_new_s      = rm_part ? (tbl_rd.start_row + row_t'(left_q)) : tbl_rd.start_row;
  assign rm_new_size32 = rm_part ? (rm_size32 - left_q) : rm_size32;

  assign lk_rel  = req_i.abs_row - offset_q;
  assign lk_diff = rel_q - tbl_rd.prefix;

  srbm_table u_table (
    .clk_i     (clk_i),
    .wr_i      (tbl_wr),
    .rd_addr_i (idx_q[IDX_W-1:0]),
    .rd_o      (tbl_rd)
  );

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = o_valid_q;
  assign rsp_o.status      = o_stat_q;
  assign rsp_o.block_index = o_idx_q;
  assign rsp_o.local_row   = o_loc_q;
  assign rsp_o.rows_held   = o_rows_q;

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    held_d     = held_q;
    total_d    = total_q;
    offset_d   = offset_q;
    idx_d      = idx_q;
    proc_d     = proc_q;
    rd_vld_d   = rd_vld_q;
    left_d     = left_q;
    drop_d     = drop_q;
    sum_d      = sum_q;
    rel_d      = rel_q;
    pick_d     = pick_q;
    loc_d      = loc_q;
    res_stat_d = res_stat_q;
    o_valid_d  = o_valid_q;
    o_stat_d   = o_stat_q;
    o_idx_d    = o_idx_q;
    o_loc_d    = o_loc_q;
    o_rows_d   = o_rows_q;
    tbl_wr     = '0;

    // Drop the pending result once the sink takes it.
    if (o_valid_q && rsp_o.ready) begin
      o_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d       = req_i.req_type;
          pick_d     = '0;
          loc_d      = '0;
          res_stat_d = STAT_OK;
          idx_d      = '0;
          rd_vld_d   = 1'b0;
          state_d    = S_FIN;
          case (req_i.req_type)
            REQ_APPEND: begin
              if (ap_e < ap_s) begin
                res_stat_d = STAT_BAD;
              end else if (held_q >= CNT_W'(MAX_BLOCKS)) begin
                res_stat_d = STAT_FULL;
              end else begin
                tbl_wr.en        = 1'b1;
                tbl_wr.addr      = held_q[IDX_W-1:0];
                tbl_wr.start_row = ap_s;
                tbl_wr.end_row   = ap_e;
                tbl_wr.prefix    = total_q;
                total_d          = total_q + 32'(ap_size);
                held_d           = held_q + CNT_W'(1);
              end
            end
            REQ_REMOVE: begin
              offset_d = offset_q + req_i.row_count;
              left_d   = req_i.row_count;
              drop_d   = '0;
              sum_d    = '0;
              state_d  = S_SCAN;
            end
            REQ_LOOKUP: begin
              if ((req_i.abs_row < offset_q) || (lk_rel >= total_q)) begin
                res_stat_d = STAT_RANGE;
              end else begin
                rel_d   = lk_rel;
                state_d = S_SCAN;
              end
            end
            default: begin
              res_stat_d = STAT_OK;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue the next table read.
        if (idx_q < held_q) begin
          idx_d    = idx_q + CNT_W'(1);
          proc_d   = idx_q[IDX_W-1:0];
          rd_vld_d = 1'b1;
        end else begin
          rd_vld_d = 1'b0;
        end

        // Process the entry read last cycle.
        if (rd_vld_q) begin
          if (op_q == REQ_REMOVE) begin
            if (rm_drop) begin
              left_d = left_q - rm_size32;
              drop_d = drop_q + CNT_W'(1);
            end else begin
              left_d           = '0;
              tbl_wr.en        = 1'b1;
              tbl_wr.addr      = proc_q - drop_q[IDX_W-1:0];
              tbl_wr.start_row = rm_new_s;
              tbl_wr.end_row   = tbl_rd.end_row;
              tbl_wr.prefix    = sum_q;
              sum_d            = sum_q + rm_new_size32;
            end
          end else begin
            if (tbl_rd.prefix <= rel_q) begin
              pick_d = proc_q;
              loc_d  = tbl_rd.start_row + row_t'(lk_diff);
            end
          end
        end

        // Walk finished: commit the new count and total for a removal.
        if ((idx_q == held_q) && !rd_vld_q) begin
          if (op_q == REQ_REMOVE) begin
            held_d  = held_q - drop_q;
            total_d = sum_q;
            pick_d  = '0;
            loc_d   = '0;
          end
          res_stat_d = STAT_OK;
          state_d    = S_FIN;
        end
      end

      S_FIN: begin
        // Hold the result until the output register is free.
        if (!o_valid_q || rsp_o.ready) begin
          o_valid_d = 1'b1;
          o_stat_d  = res_stat_q;
          o_idx_d   = 4'(pick_q);
          o_loc_d   = 16'(loc_q);
          o_rows_d  = total_q;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      op_q       <= REQ_APPEND;
      held_q     <= '0;
      total_q    <= '0;
      offset_q   <= '0;
      idx_q      <= '0;
      proc_q     <= '0;
      rd_vld_q   <= 1'b0;
      left_q     <= '0;
      drop_q     <= '0;
      sum_q      <= '0;
      rel_q      <= '0;
      pick_q     <= '0;
      loc_q      <= '0;
      res_stat_q <= STAT_OK;
      o_valid_q  <= 1'b0;
      o_stat_q   <= STAT_OK;
      o_idx_q    <= '0;
      o_loc_q    <= '0;
      o_rows_q   <= '0;
    end else begin
      state_q    <= state_d;
      op_q       <= op_d;
      held_q     <= held_d;
      total_q    <= total_d;
      offset_q   <= offset_d;
      idx_q      <= idx_d;
      proc_q     <= proc_d;
      rd_vld_q   <= rd_vld_d;
      left_q     <= left_d;
      drop_q     <= drop_d;
      sum_q      <= sum_d;
      rel_q      <= rel_d;
      pick_q     <= pick_d;
      loc_q      <= loc_d;
      res_stat_q <= res_stat_d;
      o_valid_q  <= o_valid_d;
      o_stat_q   <= o_stat_d;
      o_idx_q    <= o_idx_d;
      o_loc_q    <= o_loc_d;
      o_rows_q   <= o_rows_d;
    end
  end

endmodule

/* rtl/srbm_table.sv */
// Block table storage: start row, end row and prefix sum per entry.
// One write port, one read port with registered read data. Uses srbm_pkg.
module srbm_table (
  input  logic                       clk_i,
  input  srbm_pkg::tbl_wr_t          wr_i,
  input  logic [srbm_pkg::IDX_W-1:0] rd_addr_i,
  output srbm_pkg::tbl_rd_t          rd_o
);
  import srbm_pkg::*;

  row_t        start_mem [MAX_BLOCKS];
  row_t        end_mem   [MAX_BLOCKS];
  logic [31:0] pref_mem  [MAX_BLOCKS];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      start_mem[wr_i.addr] <= wr_i.start_row;
      end_mem[wr_i.addr]   <= wr_i.end_row;
      pref_mem[wr_i.addr]  <= wr_i.prefix;
    end
    rd_o.start_row <= start_mem[rd_addr_i];
    rd_o.end_row   <= end_mem[rd_addr_i];
    rd_o.prefix    <= pref_mem[rd_addr_i];
  end

endmodule
